// ----- rtl/core/nrt_pkg.sv -----
// Shared types, constants and a helper function for the neighbor rate table.
package nrt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int LIMIT_W = 5;
   localparam int CMP_W   = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // item actions
   localparam logic [1:0] ACT_UPDATE = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_CHECK  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THR_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_MID    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_HIGH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_RATE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LIM  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_RATE   = 3'd6;

   localparam logic signed [15:0] SNR_THR_RESET  = 16'sd25600;
   localparam logic [31:0]        MAX_AGE_RESET  = 32'd10000;
   localparam logic [31:0]        BROADCAST_ADDR = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]         action;
      logic [31:0]        address;
      logic signed [15:0] snr_db;
      logic [31:0]        now_ticks;
      logic               retry_pending;
      logic               frame_retry;
      logic [30:0]        sequence_number;
   } req_type;

   typedef struct packed {
      logic [1:0] rate_code;
      logic       is_duplicate;
      logic       not_registered;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] thr_low;
      logic signed [15:0] thr_mid;
      logic signed [15:0] thr_high;
      logic               auto_rate;
      logic [LIMIT_W-1:0] table_limit;
      logic [31:0]        max_age;
      logic [1:0]         default_rate;
   } cfg_type;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] stamp;
      logic [1:0]  rate;
      logic [30:0] last_seq;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        data;
   } wr_type;

   typedef struct packed {
      logic        match;
      logic [31:0] age;
      logic        older;
      logic        fresh;
   } alu_res_type;

   function automatic logic [1:0] pick_rate(input logic signed [15:0] snr,
                                            input cfg_type cfg);
      logic [1:0] r;
      if (snr > cfg.thr_high) r = 2'd3;
      else if (snr > cfg.thr_mid) r = 2'd2;
      else if (snr > cfg.thr_low) r = 2'd1;
      else r = 2'd0;
      return r;
   endfunction

endpackage

// ----- rtl/core/nrt_table.sv -----
// Entry storage: one write port, one registered read port.
module nrt_table (
   input  logic                      clock,
   input  nrt_pkg::wr_type           wr,
   input  logic [nrt_pkg::IDX_W-1:0] rd_idx,
   output nrt_pkg::entry_type        rd_data
);
   import nrt_pkg::*;

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/nrt_alu.sv -----
// Shared compare unit: age, address match, oldest and freshness tests.
module nrt_alu (
   input  logic                 [31:0] now_ticks,
   input  logic                 [31:0] address,
   input  nrt_pkg::entry_type          entry,
   input  logic                 [31:0] best_age,
   input  logic                 [31:0] max_age,
   output nrt_pkg::alu_res_type        res
);
   import nrt_pkg::*;

   logic [31:0] age;

   assign age       = now_ticks - entry.stamp;   // modulo 2^32
   assign res.age   = age;
   assign res.match = (entry.address == address);
   assign res.older = (age > best_age);
   assign res.fresh = (age < max_age);

endmodule

// ----- rtl/core/nrt_seq.sv -----
// Sequencer: table walk, entry update and result register.
module nrt_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  nrt_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output nrt_pkg::rsp_type            rsp_data,
   input  nrt_pkg::cfg_type            cfg,
   output logic [nrt_pkg::IDX_W-1:0]   rd_idx,
   input  nrt_pkg::entry_type          rd_data,
   output nrt_pkg::wr_type             wr,
   input  nrt_pkg::alu_res_type        alu,
   output logic [31:0]                 best_age
);
   import nrt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type          state_ff,      state_in;
   req_type            item_ff,       item_in;
   logic [IDX_W-1:0]   scan_idx_ff,   scan_idx_in;
   logic [COUNT_W-1:0] used_ff,       used_in;
   logic               found_ff,      found_in;
   logic [IDX_W-1:0]   hit_idx_ff,    hit_idx_in;
   entry_type          hit_entry_ff,  hit_entry_in;
   logic               hit_fresh_ff,  hit_fresh_in;
   logic [IDX_W-1:0]   best_idx_ff,   best_idx_in;
   logic [31:0]        best_age_ff,   best_age_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   rsp_type            rsp_data_ff,   rsp_data_in;

   logic [1:0]         rate_pick;
   logic [CMP_W-1:0]   limit;
   logic               out_free;
   logic               last_entry;

   assign rate_pick  = pick_rate(item_ff.snr_db, cfg);
   assign limit      = (CMP_W'(cfg.table_limit) > CMP_W'(TABLE_ENTRIES)) ?
                       CMP_W'(TABLE_ENTRIES) : CMP_W'(cfg.table_limit);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_entry = (COUNT_W'(scan_idx_ff) + COUNT_W'(1)) == used_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      scan_idx_in  = scan_idx_ff;
      used_in      = used_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      hit_fresh_in = hit_fresh_ff;
      best_idx_in  = best_idx_ff;
      best_age_in  = best_age_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_idx       = '0;
      wr           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in     = req_data;
               scan_idx_in = '0;
               found_in    = 1'b0;
               if (used_ff == '0 ||
                   (req_data.action != ACT_UPDATE && req_data.action != ACT_LOOKUP &&
                    req_data.action != ACT_CHECK)) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_idx = scan_idx_ff + IDX_W'(1);
            if (alu.match) begin
               found_in     = 1'b1;
               hit_idx_in   = scan_idx_ff;
               hit_entry_in = rd_data;
               hit_fresh_in = alu.fresh;
               state_in     = ST_DECIDE;
            end else begin
               if (scan_idx_ff == '0 || alu.older) begin
                  best_idx_in = scan_idx_ff;
                  best_age_in = alu.age;
               end
               if (last_entry) begin
                  state_in = ST_DECIDE;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               case (item_ff.action)
                  ACT_UPDATE: begin
                     rsp_data_in.rate_code = rate_pick;
                     wr.data.address  = item_ff.address;
                     wr.data.stamp    = item_ff.now_ticks;
                     wr.data.rate     = rate_pick;
                     wr.data.last_seq = '0;
                     if (found_ff) begin
                        wr.en            = 1'b1;
                        wr.idx           = hit_idx_ff;
                        wr.data.last_seq = hit_entry_ff.last_seq;
                     end else if (CMP_W'(used_ff) < limit) begin
                        wr.en   = 1'b1;
                        wr.idx  = used_ff[IDX_W-1:0];
                        used_in = used_ff + COUNT_W'(1);
                     end else if (used_ff != '0) begin
                        wr.en  = 1'b1;
                        wr.idx = best_idx_ff;
                     end
                  end
                  ACT_LOOKUP: begin
                     rsp_data_in.rate_code = cfg.default_rate;
                     if (cfg.auto_rate && item_ff.address != BROADCAST_ADDR &&
                         !item_ff.retry_pending && found_ff && hit_fresh_ff) begin
                        rsp_data_in.rate_code = hit_entry_ff.rate;
                     end
                  end
                  ACT_CHECK: begin
                     if (!found_ff) begin
                        rsp_data_in.not_registered = 1'b1;
                     end else if (item_ff.frame_retry &&
                                  hit_entry_ff.last_seq == item_ff.sequence_number) begin
                        rsp_data_in.is_duplicate = 1'b1;
                     end else begin
                        wr.en            = 1'b1;
                        wr.idx           = hit_idx_ff;
                        wr.data          = hit_entry_ff;
                        wr.data.last_seq = item_ff.sequence_number;
                     end
                  end
                  default: begin
                     rsp_data_in = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      scan_idx_ff  <= scan_idx_in;
      found_ff     <= found_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      hit_fresh_ff <= hit_fresh_in;
      best_idx_ff  <= best_idx_in;
      best_age_ff  <= best_age_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign best_age  = best_age_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(used_ff) <= CMP_W'(TABLE_ENTRIES))
      else $error("fill count beyond table size");

   a_write_decide: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == ST_DECIDE && out_free))
      else $error("table write outside decide step");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && used_ff != $past(used_ff)) |-> used_ff == $past(used_ff) + COUNT_W'(1))
      else $error("fill count moved by more than one");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (COUNT_W'(scan_idx_ff) < used_ff))
      else $error("walk past last used entry");

endmodule

// ----- rtl/core/neighbor_rate_table_core.sv -----
// Top level of the neighbor rate table: register bank and datapath wiring.
//
//  port group | dir | handshake            | payload
//  -----------+-----+----------------------+---------------------------------
//  req_*      | in  | req_valid/req_stall  | req_data (action, address, snr..)
//  rsp_*      | out | rsp_valid/rsp_stall  | rsp_data (rate, dup, not reg)
//  csr_*      | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// An item is accepted, then walks n entries (up to the fill count, 16 max)
// through the single table read port and the shared compare unit, then
// reaches the decide step, which waits while the result register is stalled.
// Action 3 and an empty table skip the walk.
// Reset is synchronous: fill count zero, registers at defaults; no clearing
// pass, entries beyond the fill count are never used.
// req_stall is high while an item is in work; the result register lets the
// next item in while a previous result is still stalled.
module neighbor_rate_table_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  nrt_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output nrt_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nrt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nrt_pkg::CSR_DATA_W-1:0]     csr_data
);
   import nrt_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic [IDX_W-1:0] rd_idx;
   entry_type        rd_data;
   wr_type           wr;
   alu_res_type      alu;
   logic [31:0]      best_age;
   logic [31:0]      u_seq_now;
   logic [31:0]      u_seq_addr;

   // the item held by the sequencer is the one being walked
   req_type          held_item_ff;

   // register bank, always writable
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_THR_LOW:   cfg_in.thr_low      = csr_data[15:0];
            CSR_THR_MID:   cfg_in.thr_mid      = csr_data[15:0];
            CSR_THR_HIGH:  cfg_in.thr_high     = csr_data[15:0];
            CSR_AUTO_RATE: cfg_in.auto_rate    = csr_data[0];
            CSR_TABLE_LIM: cfg_in.table_limit  = csr_data[LIMIT_W-1:0];
            CSR_MAX_AGE:   cfg_in.max_age      = csr_data[31:0];
            CSR_DEF_RATE:  cfg_in.default_rate = csr_data[1:0];
            default:       cfg_in = cfg_ff;   // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr_low      <= SNR_THR_RESET;
         cfg_ff.thr_mid      <= SNR_THR_RESET;
         cfg_ff.thr_high     <= SNR_THR_RESET;
         cfg_ff.auto_rate    <= 1'b0;
         cfg_ff.table_limit  <= '0;
         cfg_ff.max_age      <= MAX_AGE_RESET;
         cfg_ff.default_rate <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // entry storage
   nrt_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   // shared compare unit, fed with the entry just read
   nrt_alu u_alu (
      .now_ticks (u_seq_now),
      .address   (u_seq_addr),
      .entry     (rd_data),
      .best_age  (best_age),
      .max_age   (cfg_ff.max_age),
      .res       (alu)
   );

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         held_item_ff <= req_data;
      end
   end

   assign u_seq_now  = held_item_ff.now_ticks;
   assign u_seq_addr = held_item_ff.address;

   // walk, decide, write back, result register
   nrt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cfg       (cfg_ff),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data),
      .wr        (wr),
      .alu       (alu),
      .best_age  (best_age)
   );

endmodule
